>>> design/qse_pkg.sv
// Shared types and constants for the quadratic solve/evaluate block.
// No dependencies.
package qse_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int MC_W      = 64;
	localparam int MP_W      = 32;
	localparam int PROD_W    = MC_W + MP_W;
	localparam int ACC_W     = PROD_W;
	localparam int ROOT_W    = 34;
	localparam int SQ_D_W    = 2 * ROOT_W;
	localparam int SREM_W    = ROOT_W + 2;
	localparam int NUM_W     = 36;
	localparam int DEN_W     = DATA_W + 1;
	localparam int DVD_W     = NUM_W - 1 + FRAC_BITS;
	localparam int CNT_W     = $clog2(DVD_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CONSTANT = 2'd2;

	localparam logic [2:0] STAT_EVAL      = 3'd0;
	localparam logic [2:0] STAT_TWO_ROOTS = 3'd1;
	localparam logic [2:0] STAT_DOUBLE    = 3'd2;
	localparam logic [2:0] STAT_NO_ROOTS  = 3'd3;
	localparam logic [2:0] STAT_ZERO_LEAD = 3'd4;

	localparam logic CMD_EVAL  = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	// multiply phase within one request
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	typedef struct packed {
		logic              command;
		logic [DATA_W-1:0] argument;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] poly_value;
		logic [DATA_W-1:0] root_plus;
		logic [DATA_W-1:0] root_minus;
		logic [2:0]        status;
		logic              saturated;
	} rsp_t;

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

>>> design/quadratic_solve_and_evaluate.sv
// Top level: coefficient registers, bit-serial multiplier, square root and divider.
// Depends on qse_pkg.
//
//   port group   dir   handshake             contents
//   request      in    start & !busy         command, argument
//   result       out   done (1-cycle pulse)  poly_value, roots, status, saturated
//   cfg          in    cfg_we                cfg_index, cfg_data
//
// Evaluate: three 32-step shift-add multiplies.
// Solve, two roots: two multiplies, a 34-step square root and two restoring divides;
// double root: the two multiplies and one divide; no real roots: the two multiplies only.
// Solve with a zero leading coefficient answers in the cycle after the request.
// Reset restores coefficients to 1.0 and clears the kept roots; results cannot be stalled.
module quadratic_solve_and_evaluate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  qse_pkg::req_t                     request,
	output logic                              busy,
	output logic                              done,
	output qse_pkg::rsp_t                     result,
	input  logic                              cfg_we,
	input  logic [qse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qse_pkg::DATA_W-1:0]        cfg_data
);
	import qse_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL    = 8'b0000_0010,
		ST_ACC    = 8'b0000_0100,
		ST_EVFIN  = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_SQRT   = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_DIVEND = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [DATA_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic [DATA_W-1:0] kept_plus_q, kept_minus_q;
	logic              cmd_q;
	logic [DATA_W-1:0] x_q;
	logic [1:0]        step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MC_W-1:0]   mc_q;
	logic [PROD_W-1:0] p_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [SQ_D_W-1:0] sd_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [DVD_W-1:0]  dv_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  drem_q;
	logic              dneg_q;
	logic              dbl_q;
	logic              minus_q;
	logic              sq_q;
	logic              clip_q;
	logic              done_q;
	rsp_t              res_q;

	logic [MC_W:0]       mul_sum;
	logic [ACC_W-1:0]    addend;
	logic                add_neg;
	logic [SREM_W:0]     s_rem2, s_trial, s_diff;
	logic                s_ge;
	logic [DEN_W:0]      d_rem2, d_diff;
	logic                d_ge;
	logic [NUM_W-1:0]    nb, num_p, num_m, num_sel, num_mag;
	logic [DATA_W-1:0]   root_val;
	logic                root_clip;
	logic [DATA_W-1:0]   poly_val;
	logic                poly_clip;
	logic [ACC_W-2*FRAC_BITS-DATA_W:0] poly_hi;
	logic [DATA_W-1:0]   mag_a, mag_b, mag_c, mag_x;

	assign mag_a = mag32(coef_a_q);
	assign mag_b = mag32(coef_b_q);
	assign mag_c = mag32(coef_c_q);
	assign mag_x = mag32(x_q);

	always_comb begin
		mul_sum = {1'b0, p_q[PROD_W-1:MP_W]} + (p_q[0] ? {1'b0, mc_q} : '0);
		add_neg = neg_q ^ (cmd_q == CMD_SOLVE && step_q == PH_SECOND);
		if (cmd_q == CMD_EVAL && step_q == PH_THIRD) begin
			addend = p_q << FRAC_BITS;
		end else if (cmd_q == CMD_SOLVE && step_q == PH_SECOND) begin
			addend = p_q << 2;
		end else begin
			addend = p_q;
		end
		s_rem2  = {srem_q[SREM_W-2:0], sd_q[SQ_D_W-1:SQ_D_W-2]};
		s_trial = {1'b0, root_q, 2'b01};
		s_ge    = s_rem2 >= s_trial;
		s_diff  = s_rem2 - s_trial;
		d_rem2  = {drem_q, dv_q[DVD_W-1]};
		d_ge    = d_rem2 >= {1'b0, den_q};
		d_diff  = d_rem2 - {1'b0, den_q};
		nb      = ~{{(NUM_W-DATA_W){coef_b_q[DATA_W-1]}}, coef_b_q} + 1'b1;
		num_p   = nb + {{(NUM_W-ROOT_W){1'b0}}, root_q};
		num_m   = nb - {{(NUM_W-ROOT_W){1'b0}}, root_q};
		num_sel = (state_q == ST_CHECK) ? nb : (sq_q ? num_p : num_m);
		num_mag = num_sel[NUM_W-1] ? (~num_sel + 1'b1) : num_sel;
		if (dneg_q) begin
			root_clip = (|dv_q[DVD_W-1:DATA_W]) | (dv_q[DATA_W-1] & (|dv_q[DATA_W-2:0]));
			root_val  = root_clip ? {1'b1, {(DATA_W-1){1'b0}}} : (~dv_q[DATA_W-1:0] + 1'b1);
		end else begin
			root_clip = |dv_q[DVD_W-1:DATA_W-1];
			root_val  = root_clip ? {1'b0, {(DATA_W-1){1'b1}}} : dv_q[DATA_W-1:0];
		end
		poly_hi   = acc_q[ACC_W-1:2*FRAC_BITS+DATA_W-1];
		poly_clip = !((&poly_hi) || !(|poly_hi));
		if (poly_clip) begin
			poly_val = acc_q[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			poly_val = acc_q[2*FRAC_BITS+DATA_W-1:2*FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			coef_a_q     <= DATA_W'(1) << FRAC_BITS;
			coef_b_q     <= DATA_W'(1) << FRAC_BITS;
			coef_c_q     <= DATA_W'(1) << FRAC_BITS;
			kept_plus_q  <= '0;
			kept_minus_q <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_COEF_SQUARE:   coef_a_q <= cfg_data;
					REG_COEF_LINEAR:   coef_b_q <= cfg_data;
					REG_COEF_CONSTANT: coef_c_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q  <= request.command;
						x_q    <= request.argument;
						step_q <= PH_FIRST;
						clip_q <= 1'b0;
						cnt_q  <= CNT_W'(MP_W - 1);
						if (request.command == CMD_EVAL) begin
							acc_q   <= {{(ACC_W-DATA_W){coef_c_q[DATA_W-1]}}, coef_c_q}
								<< (2 * FRAC_BITS);
							mc_q    <= {{(MC_W-DATA_W){1'b0}}, mag32(request.argument)};
							p_q     <= {{(PROD_W-MP_W){1'b0}}, mag32(request.argument)};
							neg_q   <= 1'b0;
							state_q <= ST_MUL;
						end else if (coef_a_q == '0) begin
							res_q   <= '{poly_value: '0, root_plus: kept_plus_q,
								root_minus: kept_minus_q, status: STAT_ZERO_LEAD, saturated: 1'b0};
							done_q  <= 1'b1;
						end else begin
							acc_q   <= '0;
							mc_q    <= {{(MC_W-DATA_W){1'b0}}, mag_b};
							p_q     <= {{(PROD_W-MP_W){1'b0}}, mag_b};
							neg_q   <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					p_q   <= {mul_sum, p_q[MP_W-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					cnt_q <= CNT_W'(MP_W - 1);
					if (cmd_q == CMD_EVAL && step_q == PH_FIRST) begin
						mc_q    <= p_q[MC_W-1:0];
						p_q     <= {{(PROD_W-MP_W){1'b0}}, mag_a};
						neg_q   <= coef_a_q[DATA_W-1];
						step_q  <= PH_SECOND;
						state_q <= ST_MUL;
					end else begin
						acc_q <= add_neg ? (acc_q - addend) : (acc_q + addend);
						if (cmd_q == CMD_EVAL && step_q == PH_SECOND) begin
							mc_q    <= {{(MC_W-DATA_W){1'b0}}, mag_x};
							p_q     <= {{(PROD_W-MP_W){1'b0}}, mag_b};
							neg_q   <= coef_b_q[DATA_W-1] ^ x_q[DATA_W-1];
							step_q  <= PH_THIRD;
							state_q <= ST_MUL;
						end else if (cmd_q == CMD_EVAL) begin
							state_q <= ST_EVFIN;
						end else if (step_q != PH_FIRST) begin
							state_q <= ST_CHECK;
						end else begin
							mc_q    <= {{(MC_W-DATA_W){1'b0}}, mag_a};
							p_q     <= {{(PROD_W-MP_W){1'b0}}, mag_c};
							neg_q   <= coef_a_q[DATA_W-1] ^ coef_c_q[DATA_W-1];
							step_q  <= PH_SECOND;
							state_q <= ST_MUL;
						end
					end
				end
				ST_EVFIN: begin
					res_q   <= '{poly_value: poly_val, root_plus: kept_plus_q,
						root_minus: kept_minus_q, status: STAT_EVAL, saturated: poly_clip};
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CHECK: begin
					dbl_q   <= 1'b0;
					minus_q <= 1'b0;
					if (acc_q[ACC_W-1]) begin
						res_q   <= '{poly_value: '0, root_plus: kept_plus_q,
							root_minus: kept_minus_q, status: STAT_NO_ROOTS, saturated: 1'b0};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (acc_q == '0) begin
						dbl_q   <= 1'b1;
						dv_q    <= {num_mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
						dneg_q  <= num_sel[NUM_W-1] ^ coef_a_q[DATA_W-1];
						drem_q  <= '0;
						den_q   <= {mag_a, 1'b0};
						cnt_q   <= CNT_W'(DVD_W - 1);
						state_q <= ST_DIV;
					end else begin
						sd_q    <= acc_q[SQ_D_W-1:0];
						srem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					sd_q   <= sd_q << 2;
					srem_q <= s_ge ? s_diff[SREM_W-1:0] : s_rem2[SREM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], s_ge};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DIVEND;
						sq_q    <= 1'b1;
					end
				end
				ST_DIV: begin
					dv_q   <= {dv_q[DVD_W-2:0], d_ge};
					drem_q <= d_ge ? d_diff[DEN_W-1:0] : d_rem2[DEN_W-1:0];
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: begin
					if (dbl_q) begin
						kept_plus_q  <= root_val;
						kept_minus_q <= root_val;
						res_q   <= '{poly_value: '0, root_plus: root_val,
							root_minus: root_val, status: STAT_DOUBLE, saturated: root_clip};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (minus_q) begin
						kept_minus_q <= root_val;
						res_q   <= '{poly_value: '0, root_plus: kept_plus_q,
							root_minus: root_val, status: STAT_TWO_ROOTS,
							saturated: clip_q | root_clip};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						// sq_q: root just found, plus divide still to start
						if (!sq_q) begin
							kept_plus_q <= root_val;
							clip_q      <= root_clip;
							minus_q     <= 1'b1;
						end
						sq_q    <= 1'b0;
						dv_q    <= {num_mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
						dneg_q  <= num_sel[NUM_W-1] ^ coef_a_q[DATA_W-1];
						drem_q  <= '0;
						den_q   <= {mag_a, 1'b0};
						cnt_q   <= CNT_W'(DVD_W - 1);
						state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result strobe without a request in flight");

	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_DOUBLE |-> result.root_plus == result.root_minus)
		else $error("double root with differing roots");

	a_solve_poly_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STAT_EVAL |-> result.poly_value == '0)
		else $error("nonzero polynomial value on a solve result");

endmodule
